@@ rtl/udprc_pkg.sv @@
// Shared types, constants and checksum helper for the UDP receive checker.
package udprc_pkg;

  localparam int unsigned HEADER_BYTES    = 8;
  localparam logic [15:0] UDP_PROTOCOL    = 16'd17;
  localparam logic [15:0] IGNORE_CHECKSUM = 16'h0000;
  localparam logic [16:0] SUM_ALL_ONES    = 17'h0FFFF;
  localparam int unsigned FIFO_DEPTH      = 4;

  localparam int unsigned NUM_COUNTERS  = 5;
  localparam int unsigned CNT_MISMATCH  = 0;
  localparam int unsigned CNT_BADSUM    = 1;
  localparam int unsigned CNT_UNCHECKED = 2;
  localparam int unsigned CNT_TOTAL_BAD = 3;
  localparam int unsigned CNT_RECEIVED  = 4;

  typedef enum logic [1:0] {
    VERDICT_CHECKED   = 2'd0,
    VERDICT_UNCHECKED = 2'd1,
    VERDICT_LENGTH    = 2'd2,
    VERDICT_BAD_SUM   = 2'd3
  } udprc_verdict_e;

  typedef enum logic [1:0] {
    HDR_SRC_PORT = 2'd0,
    HDR_DST_PORT = 2'd1,
    HDR_LENGTH   = 2'd2,
    HDR_CHECKSUM = 2'd3
  } udprc_hdr_field_e;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             first;
    logic             payload;
    logic             in_sum;
    logic             odd_pos;
    logic             is_hdr;
    udprc_hdr_field_e hdr_field;
    logic             len_bad;
    logic [15:0]      count;
    logic [16:0]      pseudo_sum;
  } udprc_item_t;

  function automatic logic [16:0] add_ones(input logic [16:0] acc, input logic [15:0] word);
    logic [17:0] s;
    s = {1'b0, acc} + {2'b00, word};
    return 17'(s[15:0]) + 17'(s[17:16]);
  endfunction

endpackage

@@ rtl/udprc_fifo.sv @@
// Small register queue between the classifying front and the checking back.
module udprc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != CntFull);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

@@ rtl/udprc_front.sv @@
// Front end: byte position tracking, header classification and pseudo-header sum.
module udprc_front #(
  parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic [31:0]           source_address_i,
  input  logic [31:0]           dest_address_i,
  output udprc_pkg::udprc_item_t item_o
);

  localparam int unsigned PosW = $clog2(MAX_DATAGRAM_BYTES + 2);
  localparam logic [PosW-1:0] PosMax   = PosW'(MAX_DATAGRAM_BYTES);
  localparam logic [PosW-1:0] PosLimit = PosW'(MAX_DATAGRAM_BYTES + 1);
  localparam logic [PosW-1:0] PosHdr   = PosW'(udprc_pkg::HEADER_BYTES);

  logic [PosW-1:0] pos_q, pos_d, count;
  logic [16:0]     pseudo;

  assign count = (pos_q < PosMax) ? pos_q + 1'b1 : PosLimit;

  always_comb begin
    pseudo = udprc_pkg::add_ones(17'd0, source_address_i[31:16]);
    pseudo = udprc_pkg::add_ones(pseudo, source_address_i[15:0]);
    pseudo = udprc_pkg::add_ones(pseudo, dest_address_i[31:16]);
    pseudo = udprc_pkg::add_ones(pseudo, dest_address_i[15:0]);
    pseudo = udprc_pkg::add_ones(pseudo, udprc_pkg::UDP_PROTOCOL);
  end

  always_comb begin
    item_o            = '0;
    item_o.data       = data_byte_i;
    item_o.last       = last_byte_i;
    item_o.first      = (pos_q == '0);
    item_o.payload    = (pos_q >= PosHdr);
    item_o.in_sum     = (pos_q < PosMax);
    item_o.odd_pos    = pos_q[0];
    item_o.is_hdr     = (pos_q < PosHdr);
    item_o.hdr_field  = udprc_pkg::udprc_hdr_field_e'(pos_q[2:1]);
    item_o.len_bad    = (count > PosMax) || (count < PosHdr);
    item_o.count      = 16'(count);
    item_o.pseudo_sum = pseudo;
  end

  always_comb begin
    pos_d = pos_q;
    if (in_valid_i && in_ready_i) begin
      pos_d = last_byte_i ? '0 : count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

@@ rtl/udprc_back.sv @@
// Back end: header fields, running checksum, verdict, counters and output register.
module udprc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  udprc_pkg::udprc_item_t item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [7:0]            payload_byte_o,
  output logic                  payload_valid_o,
  output logic                  end_of_datagram_o,
  output logic [1:0]            verdict_o,
  output logic [15:0]           source_port_o,
  output logic [15:0]           dest_port_o,
  output logic [31:0]           length_mismatch_count_o,
  output logic [31:0]           bad_checksum_count_o,
  output logic [31:0]           unchecked_count_o,
  output logic [31:0]           total_bad_count_o,
  output logic [31:0]           total_received_count_o
);

  logic [15:0] sport_q, sport_d, dport_q, dport_d, len_q, len_d, csum_q, csum_d;
  logic [16:0] rsum_q, rsum_d, fin;
  logic [7:0]  odd_q, odd_d;
  logic [31:0] cnt_q [udprc_pkg::NUM_COUNTERS];
  logic [31:0] cnt_d [udprc_pkg::NUM_COUNTERS];
  logic        has_result, pop, chk_ok;
  udprc_pkg::udprc_verdict_e verdict;

  logic                      out_valid_q;
  logic [7:0]                out_byte_q;
  logic                      out_pv_q, out_last_q;
  udprc_pkg::udprc_verdict_e out_verdict_q;
  logic [15:0]               out_sport_q, out_dport_q;

  assign has_result   = item_i.payload || item_i.last;
  assign item_ready_o = !has_result || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  always_comb begin
    sport_d = sport_q;
    dport_d = dport_q;
    len_d   = len_q;
    csum_d  = csum_q;
    odd_d   = odd_q;
    rsum_d  = item_i.first ? item_i.pseudo_sum : rsum_q;
    if (item_i.is_hdr) begin
      unique case (item_i.hdr_field)
        udprc_pkg::HDR_SRC_PORT: sport_d = {sport_q[7:0], item_i.data};
        udprc_pkg::HDR_DST_PORT: dport_d = {dport_q[7:0], item_i.data};
        udprc_pkg::HDR_LENGTH:   len_d   = {len_q[7:0], item_i.data};
        udprc_pkg::HDR_CHECKSUM: csum_d  = {csum_q[7:0], item_i.data};
        default: ;
      endcase
    end
    if (item_i.in_sum) begin
      if (!item_i.odd_pos) begin
        odd_d = item_i.data;
      end else begin
        rsum_d = udprc_pkg::add_ones(rsum_d, {odd_q, item_i.data});
      end
    end
    fin = rsum_d;
    if (item_i.count[0]) begin
      fin = udprc_pkg::add_ones(fin, {odd_d, 8'h00});
    end
    fin    = udprc_pkg::add_ones(fin, len_d);
    fin    = udprc_pkg::add_ones(fin, 16'h0000);
    chk_ok = (fin == udprc_pkg::SUM_ALL_ONES);
    if (!item_i.last) begin
      verdict = udprc_pkg::VERDICT_CHECKED;
    end else if (item_i.len_bad || (item_i.count != len_d)) begin
      verdict = udprc_pkg::VERDICT_LENGTH;
    end else if (csum_d == udprc_pkg::IGNORE_CHECKSUM) begin
      verdict = udprc_pkg::VERDICT_UNCHECKED;
    end else if (chk_ok) begin
      verdict = udprc_pkg::VERDICT_CHECKED;
    end else begin
      verdict = udprc_pkg::VERDICT_BAD_SUM;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (pop && item_i.last) begin
      case (verdict)
        udprc_pkg::VERDICT_LENGTH: begin
          cnt_d[udprc_pkg::CNT_MISMATCH]  = cnt_q[udprc_pkg::CNT_MISMATCH] + 32'd1;
          cnt_d[udprc_pkg::CNT_TOTAL_BAD] = cnt_q[udprc_pkg::CNT_TOTAL_BAD] + 32'd1;
        end
        udprc_pkg::VERDICT_BAD_SUM: begin
          cnt_d[udprc_pkg::CNT_BADSUM]    = cnt_q[udprc_pkg::CNT_BADSUM] + 32'd1;
          cnt_d[udprc_pkg::CNT_TOTAL_BAD] = cnt_q[udprc_pkg::CNT_TOTAL_BAD] + 32'd1;
        end
        udprc_pkg::VERDICT_UNCHECKED: begin
          cnt_d[udprc_pkg::CNT_UNCHECKED] = cnt_q[udprc_pkg::CNT_UNCHECKED] + 32'd1;
          cnt_d[udprc_pkg::CNT_RECEIVED]  = cnt_q[udprc_pkg::CNT_RECEIVED] + 32'd1;
        end
        default: begin
          cnt_d[udprc_pkg::CNT_RECEIVED]  = cnt_q[udprc_pkg::CNT_RECEIVED] + 32'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sport_q     <= '0;
      dport_q     <= '0;
      len_q       <= '0;
      csum_q      <= '0;
      rsum_q      <= '0;
      odd_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < udprc_pkg::NUM_COUNTERS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
      if (pop) begin
        if (item_i.last) begin
          sport_q <= '0;
          dport_q <= '0;
          len_q   <= '0;
          csum_q  <= '0;
          rsum_q  <= '0;
          odd_q   <= '0;
        end else begin
          sport_q <= sport_d;
          dport_q <= dport_d;
          len_q   <= len_d;
          csum_q  <= csum_d;
          rsum_q  <= rsum_d;
          odd_q   <= odd_d;
        end
      end
      if (pop && has_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && has_result) begin
      out_byte_q    <= item_i.payload ? item_i.data : 8'h00;
      out_pv_q      <= item_i.payload;
      out_last_q    <= item_i.last;
      out_verdict_q <= verdict;
      out_sport_q   <= sport_d;
      out_dport_q   <= dport_d;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign payload_byte_o          = out_byte_q;
  assign payload_valid_o         = out_pv_q;
  assign end_of_datagram_o       = out_last_q;
  assign verdict_o               = out_verdict_q;
  assign source_port_o           = out_sport_q;
  assign dest_port_o             = out_dport_q;
  assign length_mismatch_count_o = cnt_q[udprc_pkg::CNT_MISMATCH];
  assign bad_checksum_count_o    = cnt_q[udprc_pkg::CNT_BADSUM];
  assign unchecked_count_o       = cnt_q[udprc_pkg::CNT_UNCHECKED];
  assign total_bad_count_o       = cnt_q[udprc_pkg::CNT_TOTAL_BAD];
  assign total_received_count_o  = cnt_q[udprc_pkg::CNT_RECEIVED];

endmodule

@@ rtl/udp_receive_checker_unit.sv @@
// Top level of the UDP receive checker: front end, item queue and back end.
//
//  channel  | direction | tdata                                  | tuser          | tlast
//  s_axis   | in        | data_byte, source_address, dest_addr   | -              | last_byte
//  m_axis   | out       | payload_byte, ports, five counters     | pvalid,verdict | end_of_datagram
//
// One byte per cycle sustained while m_axis_tready is high; the front end is combinational, so a
// byte is written into the queue at its transfer and then moved into the output register. Header
// bytes that are not last produce no output transfer. The back end stalls only on m_axis_tready;
// the four-entry queue absorbs that stall before s_axis_tready drops. Reset clears position,
// header state, checksum and all five counters.
module udp_receive_checker_unit #(
  parameter int unsigned MAX_DATAGRAM_BYTES = 65535
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // data_byte[7:0], source_address[39:8], dest_address[71:40]
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [199:0] m_axis_tdata,   // payload_byte[7:0], source_port[23:8],
                                       // dest_port[39:24], length_mismatch_count[71:40],
                                       // bad_checksum_count[103:72], unchecked_count[135:104],
                                       // total_bad_count[167:136],
                                       // total_received_count[199:168]
  output logic [2:0]   m_axis_tuser,   // payload_valid[0], verdict[2:1]
  output logic         m_axis_tlast
);

  udprc_pkg::udprc_item_t front_item, back_item;
  logic                   q_valid, q_ready;

  udprc_front #(
    .MAX_DATAGRAM_BYTES(MAX_DATAGRAM_BYTES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_i      (s_axis_tready),
    .data_byte_i     (s_axis_tdata[7:0]),
    .last_byte_i     (s_axis_tlast),
    .source_address_i(s_axis_tdata[39:8]),
    .dest_address_i  (s_axis_tdata[71:40]),
    .item_o          (front_item)
  );

  udprc_fifo #(
    .WIDTH($bits(udprc_pkg::udprc_item_t)),
    .DEPTH(udprc_pkg::FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(s_axis_tvalid),
    .wr_ready_o(s_axis_tready),
    .wr_data_i (front_item),
    .rd_valid_o(q_valid),
    .rd_ready_i(q_ready),
    .rd_data_o (back_item)
  );

  udprc_back u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .item_valid_i           (q_valid),
    .item_ready_o           (q_ready),
    .item_i                 (back_item),
    .out_valid_o            (m_axis_tvalid),
    .out_ready_i            (m_axis_tready),
    .payload_byte_o         (m_axis_tdata[7:0]),
    .payload_valid_o        (m_axis_tuser[0]),
    .end_of_datagram_o      (m_axis_tlast),
    .verdict_o              (m_axis_tuser[2:1]),
    .source_port_o          (m_axis_tdata[23:8]),
    .dest_port_o            (m_axis_tdata[39:24]),
    .length_mismatch_count_o(m_axis_tdata[71:40]),
    .bad_checksum_count_o   (m_axis_tdata[103:72]),
    .unchecked_count_o      (m_axis_tdata[135:104]),
    .total_bad_count_o      (m_axis_tdata[167:136]),
    .total_received_count_o (m_axis_tdata[199:168])
  );

endmodule

@@ tb/sv/udp_receive_checker_unit_tb.sv @@
// Self-checking stream testbench for udp_receive_checker_unit with a built-in datagram model.
`timescale 1ns / 1ps

module udp_receive_checker_unit_tb;

  localparam int unsigned MAX_BYTES   = 65535;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned RANDOM_BYTES = 1400;

  typedef enum int {
    DG_GOOD,
    DG_NO_SUM,
    DG_BAD_SUM,
    DG_BAD_LEN,
    DG_SHORT,
    DG_NOISE
  } dg_kind_e;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] src;
    logic [31:0] dst;
  } wire_byte_t;

  typedef struct packed {
    logic [7:0]                               payload_byte;
    logic                                     payload_valid;
    logic                                     end_of_datagram;
    udprc_pkg::udprc_verdict_e                verdict;
    logic [15:0]                              source_port;
    logic [15:0]                              dest_port;
    logic [udprc_pkg::NUM_COUNTERS-1:0][31:0] tallies;
  } udp_output_t;

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // data_byte[7:0], source_address[39:8], dest_address[71:40]
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;        // payload_byte, source_port, dest_port, five counters
  logic [2:0]   m_axis_tuser;        // payload_valid[0], verdict[2:1]
  logic         m_axis_tlast;

  udp_receive_checker_unit #(
    .MAX_DATAGRAM_BYTES(MAX_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  wire_byte_t  pending_bytes[$];
  udp_output_t due_outputs[$];

  int unsigned dg_position;
  logic [15:0] dg_length;
  logic [15:0] dg_src_port;
  logic [15:0] dg_dst_port;
  logic [15:0] dg_checksum;
  logic [31:0] dg_sum;
  logic [7:0]  dg_high_byte;
  logic [31:0] tally [udprc_pkg::NUM_COUNTERS];

  string tally_name [udprc_pkg::NUM_COUNTERS] = '{"length_mismatch_count", "bad_checksum_count",
                                                  "unchecked_count", "total_bad_count",
                                                  "total_received_count"};

  int unsigned fail_count;
  int unsigned idle_cycles;
  int unsigned outputs_checked;
  int unsigned datagrams_queued;
  int unsigned bytes_queued;
  int unsigned burst_left;
  int unsigned gap_left;
  logic        steady_flow = 1'b0;
  logic [15:0] ready_pattern;
  logic [3:0]  ready_phase;
  wire_byte_t  drive_item;
  udp_output_t seen, want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] ones_add(input logic [31:0] acc, input logic [15:0] word);
    logic [31:0] s;
    s = acc + {16'h0, word};
    return {16'h0, s[15:0]} + (s >> 16);
  endfunction

  task automatic track_datagram_byte(input logic [7:0] data, input logic last,
                                     input logic [31:0] src, input logic [31:0] dst);
    int unsigned pos;
    int unsigned count;
    logic        payload;
    logic [31:0] folded;
    udp_output_t res;
    pos     = dg_position;
    count   = (pos + 1 < MAX_BYTES + 1) ? pos + 1 : MAX_BYTES + 1;
    payload = pos >= udprc_pkg::HEADER_BYTES;
    res     = '0;
    res.verdict = udprc_pkg::VERDICT_CHECKED;
    if (pos == 0) begin
      dg_sum = ones_add(32'h0, src[31:16]);
      dg_sum = ones_add(dg_sum, src[15:0]);
      dg_sum = ones_add(dg_sum, dst[31:16]);
      dg_sum = ones_add(dg_sum, dst[15:0]);
      dg_sum = ones_add(dg_sum, udprc_pkg::UDP_PROTOCOL);
    end
    case (pos)
      0, 1: dg_src_port = {dg_src_port[7:0], data};
      2, 3: dg_dst_port = {dg_dst_port[7:0], data};
      4, 5: dg_length   = {dg_length[7:0], data};
      6, 7: dg_checksum = {dg_checksum[7:0], data};
      default: ;
    endcase
    if (pos < MAX_BYTES) begin
      if (pos % 2 == 0) dg_high_byte = data;
      else dg_sum = ones_add(dg_sum, {dg_high_byte, data});
    end
    if (last) begin
      if (count > MAX_BYTES || count < udprc_pkg::HEADER_BYTES || count != dg_length) begin
        res.verdict = udprc_pkg::VERDICT_LENGTH;
        tally[udprc_pkg::CNT_MISMATCH]  += 1;
        tally[udprc_pkg::CNT_TOTAL_BAD] += 1;
      end else if (dg_checksum == udprc_pkg::IGNORE_CHECKSUM) begin
        res.verdict = udprc_pkg::VERDICT_UNCHECKED;
        tally[udprc_pkg::CNT_UNCHECKED] += 1;
        tally[udprc_pkg::CNT_RECEIVED]  += 1;
      end else begin
        folded = dg_sum;
        if (count % 2 != 0) folded = ones_add(folded, {dg_high_byte, 8'h00});
        folded = ones_add(folded, dg_length);
        folded = ones_add(folded, 16'h0000);
        if (folded == 32'(udprc_pkg::SUM_ALL_ONES)) begin
          res.verdict = udprc_pkg::VERDICT_CHECKED;
          tally[udprc_pkg::CNT_RECEIVED] += 1;
        end else begin
          res.verdict = udprc_pkg::VERDICT_BAD_SUM;
          tally[udprc_pkg::CNT_BADSUM]    += 1;
          tally[udprc_pkg::CNT_TOTAL_BAD] += 1;
        end
      end
    end else begin
      dg_position = count;
    end
    if (payload || last) begin
      res.payload_byte    = payload ? data : 8'h00;
      res.payload_valid   = payload;
      res.end_of_datagram = last;
      res.source_port     = dg_src_port;
      res.dest_port       = dg_dst_port;
      for (int k = 0; k < udprc_pkg::NUM_COUNTERS; k++) res.tallies[k] = tally[k];
      due_outputs.push_back(res);
    end
    if (last) begin
      dg_position  = 0;
      dg_length    = '0;
      dg_src_port  = '0;
      dg_dst_port  = '0;
      dg_checksum  = '0;
      dg_sum       = '0;
      dg_high_byte = '0;
    end
  endtask

  // Short kind takes body_len as the whole byte count; noise sends body_len + 1 random bytes.
  task automatic queue_datagram(input dg_kind_e kind, input int unsigned body_len,
                                input logic [31:0] src, input logic [31:0] dst,
                                input logic [31:0] ports);
    logic [7:0]  octets[];
    int unsigned total;
    logic [15:0] len_field;
    logic [15:0] good_sum;
    logic [15:0] sum_field;
    logic [31:0] acc;
    wire_byte_t  item;
    total = (kind == DG_SHORT) ? body_len :
            (kind == DG_NOISE) ? body_len + 1 : body_len + udprc_pkg::HEADER_BYTES;
    octets = new[total];
    foreach (octets[i]) octets[i] = 8'($urandom);
    if (kind != DG_SHORT && kind != DG_NOISE) begin
      len_field = 16'(total);
      if (kind == DG_BAD_LEN) begin
        do begin
          len_field = $urandom_range(0, 1) ? 16'($urandom) : 16'(total - 2 + $urandom_range(0, 4));
        end while (len_field == 16'(total));
      end
      octets[0] = ports[31:24];
      octets[1] = ports[23:16];
      octets[2] = ports[15:8];
      octets[3] = ports[7:0];
      octets[4] = len_field[15:8];
      octets[5] = len_field[7:0];
      octets[6] = 8'h00;
      octets[7] = 8'h00;
      acc = src[31:16] + src[15:0] + dst[31:16] + dst[15:0] + udprc_pkg::UDP_PROTOCOL
            + len_field;
      for (int i = 0; i < total; i += 2)
        acc += {octets[i], (i + 1 < total) ? octets[i + 1] : 8'h00};
      acc = acc[15:0] + acc[31:16];
      acc = acc[15:0] + acc[31:16];
      good_sum = ~acc[15:0];
      if (good_sum == 16'h0000) good_sum = 16'hFFFF;
      case (kind)
        DG_NO_SUM: sum_field = udprc_pkg::IGNORE_CHECKSUM;
        DG_BAD_SUM: begin
          do sum_field = 16'($urandom);
          while (sum_field == udprc_pkg::IGNORE_CHECKSUM || sum_field == good_sum);
        end
        default: sum_field = good_sum;
      endcase
      octets[6] = sum_field[15:8];
      octets[7] = sum_field[7:0];
    end
    for (int i = 0; i < total; i++) begin
      item.data = octets[i];
      item.last = (i == total - 1);
      item.src  = (i == 0) ? src : $urandom;
      item.dst  = (i == 0) ? dst : $urandom;
      pending_bytes.push_back(item);
    end
    datagrams_queued++;
    bytes_queued += total;
  endtask

  task automatic wait_for_drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || due_outputs.size() != 0)
      @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0 && !steady_flow) begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= gap_left - 1;
      end else if (pending_bytes.size() != 0) begin
        drive_item = pending_bytes.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drive_item.dst, drive_item.src, drive_item.data};
        s_axis_tlast  <= drive_item.last;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
          gap_left   <= 0;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
        gap_left      <= 0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      ready_pattern <= '1;
      ready_phase   <= '0;
    end else begin
      m_axis_tready <= steady_flow | ready_pattern[ready_phase];
      ready_phase   <= ready_phase + 1;
      if (ready_phase == 4'hF) begin
        case ($urandom_range(0, 7))
          0, 1: ready_pattern <= '1;
          2:    ready_pattern <= 16'h0001;
          3:    ready_pattern <= 16'($urandom);
          default: ready_pattern <= 16'($urandom) | 16'($urandom);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen.payload_byte    = m_axis_tdata[7:0];
        seen.source_port     = m_axis_tdata[23:8];
        seen.dest_port       = m_axis_tdata[39:24];
        for (int k = 0; k < udprc_pkg::NUM_COUNTERS; k++)
          seen.tallies[k] = m_axis_tdata[40 + 32 * k +: 32];
        seen.payload_valid   = m_axis_tuser[0];
        seen.verdict         = udprc_pkg::udprc_verdict_e'(m_axis_tuser[2:1]);
        seen.end_of_datagram = m_axis_tlast;
        if (due_outputs.size() == 0) begin
          $error("output transfer with no expected result pending");
          fail_count++;
        end else begin
          want = due_outputs.pop_front();
          if (seen.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, got %0h", want.payload_byte, seen.payload_byte);
            fail_count++;
          end
          if (seen.payload_valid !== want.payload_valid) begin
            $error("payload_valid: expected %0d, got %0d", want.payload_valid,
                   seen.payload_valid);
            fail_count++;
          end
          if (seen.end_of_datagram !== want.end_of_datagram) begin
            $error("end_of_datagram: expected %0d, got %0d", want.end_of_datagram,
                   seen.end_of_datagram);
            fail_count++;
          end
          if (seen.verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, seen.verdict);
            fail_count++;
          end
          if (seen.source_port !== want.source_port) begin
            $error("source_port: expected %0h, got %0h", want.source_port, seen.source_port);
            fail_count++;
          end
          if (seen.dest_port !== want.dest_port) begin
            $error("dest_port: expected %0h, got %0h", want.dest_port, seen.dest_port);
            fail_count++;
          end
          for (int k = 0; k < udprc_pkg::NUM_COUNTERS; k++) begin
            if (seen.tallies[k] !== want.tallies[k]) begin
              $error("%s: expected %0d, got %0d", tally_name[k], want.tallies[k],
                     seen.tallies[k]);
              fail_count++;
            end
          end
        end
        outputs_checked++;
      end
      if (s_axis_tvalid && s_axis_tready)
        track_datagram_byte(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[39:8],
                            s_axis_tdata[71:40]);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    dg_kind_e    kind;
    int unsigned pick;
    int unsigned body;
    int unsigned random_start;
    dg_position  = 0;
    dg_length    = '0;
    dg_src_port  = '0;
    dg_dst_port  = '0;
    dg_checksum  = '0;
    dg_sum       = '0;
    dg_high_byte = '0;
    for (int k = 0; k < udprc_pkg::NUM_COUNTERS; k++) tally[k] = '0;
    fail_count       = 0;
    idle_cycles      = 0;
    outputs_checked  = 0;
    datagrams_queued = 0;
    bytes_queued     = 0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_datagram(DG_GOOD, 0, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000);
    queue_datagram(DG_SHORT, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    queue_datagram(DG_NO_SUM, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF);
    queue_datagram(DG_BAD_LEN, 0, 32'h8000_0001, 32'h0000_0001, 32'h1234_5678);
    wait_for_drain();

    random_start = bytes_queued;
    while (bytes_queued - random_start < RANDOM_BYTES) begin
      while (pending_bytes.size() > 64) @(posedge clk_i);
      steady_flow <= (bytes_queued - random_start > 500) && (bytes_queued - random_start < 750);
      pick = $urandom_range(0, 99);
      kind = (pick < 40) ? DG_GOOD :
             (pick < 50) ? DG_NO_SUM :
             (pick < 65) ? DG_BAD_SUM :
             (pick < 78) ? DG_BAD_LEN :
             (pick < 90) ? DG_SHORT : DG_NOISE;
      body = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300) : $urandom_range(0, 24);
      if (kind == DG_SHORT) body = $urandom_range(1, udprc_pkg::HEADER_BYTES - 1);
      queue_datagram(kind, body, $urandom, $urandom, $urandom);
    end
    steady_flow <= 1'b0;

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d datagrams (%0d bytes): good, unchecked, bad sum, bad length, short, noise.",
             datagrams_queued, bytes_queued);
    $display("Random gaps and output stalls; %0d outputs checked, %0d dropped, %0d accepted.",
             outputs_checked, tally[udprc_pkg::CNT_TOTAL_BAD], tally[udprc_pkg::CNT_RECEIVED]);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/udprc_pkg.sv
rtl/udprc_fifo.sv
rtl/udprc_front.sv
rtl/udprc_back.sv
rtl/udp_receive_checker_unit.sv
tb/sv/udp_receive_checker_unit_tb.sv
